// ===== hw/rtl/tcwq_pkg.sv =====
// types and constants shared by the two-class weighted queue
package tcwq_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned NUMBER_W = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 4'd5;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [NUMBER_W-1:0] t_number;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [COUNT_W-1:0]  t_count;

    localparam t_func FUNC_ENQ_NORMAL = 2'd0;
    localparam t_func FUNC_ENQ_PREF   = 2'd1;
    localparam t_func FUNC_SERVE      = 2'd2;

    localparam t_status STATUS_SERVED_NORMAL = 3'd0;
    localparam t_status STATUS_SERVED_PREF   = 3'd1;
    localparam t_status STATUS_EMPTY         = 3'd2;
    localparam t_status STATUS_ENQUEUED      = 3'd3;
    localparam t_status STATUS_FULL          = 3'd4;

endpackage

// ===== hw/rtl/two_class_weighted_queue_unit.sv =====
// top level of the two-class weighted queue: two ticket fifos and a service arbiter
//
// requests enter on the s_axis channel: tuser carries the function (enqueue normal,
// enqueue preferred, serve; the unused code also serves), tdata the ticket number.
// every request gives exactly one result on the m_axis channel: tuser carries the
// status, tdata the served ticket number or zero when nothing was served.
// the threshold of preferred services in a row is written on the cfg channel,
// which is always ready; write it only while no request is in flight.
// one request is taken per cycle while s_axis_tready is high. a result passes through
// the result stage, loaded with the queue update and registered store read, and then
// the output register before it shows on m_axis.
// when the receiver stalls, one result waits in the output register and one in the
// stage before it; s_axis_tready drops only when both are full.
// reset empties both queues, clears the service counter and sets the threshold
// to five; the stores are not cleared and need no clearing pass.
module two_class_weighted_queue_unit
    import tcwq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data,     // serve_threshold
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // ticket_number
    input  logic [FUNC_W-1:0]   s_axis_tuser,   // func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // served_number
    output logic [STATUS_W-1:0] m_axis_tuser    // status
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    t_number r_norm_mem [QUEUE_DEPTH];
    t_number r_pref_mem [QUEUE_DEPTH];

    logic [AW-1:0] r_norm_head, r_norm_tail, r_pref_head, r_pref_tail;
    logic [FW-1:0] r_norm_fill, r_pref_fill;
    t_count        r_count, r_threshold;

    logic [AW-1:0] n_norm_head, n_norm_tail, n_pref_head, n_pref_tail;
    logic [FW-1:0] n_norm_fill, n_pref_fill;
    t_count        n_count;

    logic    r_p_valid, r_o_valid;
    t_status r_p_status, r_o_status;
    t_number r_p_number, r_o_number;

    logic    accept, out_load, norm_empty, pref_empty, serve_normal;
    logic    norm_write, pref_write, norm_read, pref_read;
    t_status n_status;

    assign o_cfg_ready   = 1'b1;
    assign out_load      = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_p_valid || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign norm_empty   = (r_norm_fill == '0);
    assign pref_empty   = (r_pref_fill == '0);
    assign serve_normal = pref_empty || (!norm_empty && (r_count >= r_threshold));

    always_comb begin
        n_norm_head = r_norm_head;
        n_norm_tail = r_norm_tail;
        n_norm_fill = r_norm_fill;
        n_pref_head = r_pref_head;
        n_pref_tail = r_pref_tail;
        n_pref_fill = r_pref_fill;
        n_count     = r_count;
        norm_write  = 1'b0;
        pref_write  = 1'b0;
        norm_read   = 1'b0;
        pref_read   = 1'b0;
        case (s_axis_tuser)
            FUNC_ENQ_NORMAL: begin
                if (r_norm_fill == FULL_FILL) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_status    = STATUS_ENQUEUED;
                    norm_write  = 1'b1;
                    n_norm_tail = (r_norm_tail == LAST_IDX) ? '0 : r_norm_tail + 1'b1;
                    n_norm_fill = r_norm_fill + 1'b1;
                end
            end
            FUNC_ENQ_PREF: begin
                if (r_pref_fill == FULL_FILL) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_status    = STATUS_ENQUEUED;
                    pref_write  = 1'b1;
                    n_pref_tail = (r_pref_tail == LAST_IDX) ? '0 : r_pref_tail + 1'b1;
                    n_pref_fill = r_pref_fill + 1'b1;
                end
            end
            default: begin
                if (norm_empty && pref_empty) begin
                    n_status = STATUS_EMPTY;
                end else if (serve_normal) begin
                    n_status    = STATUS_SERVED_NORMAL;
                    norm_read   = 1'b1;
                    n_norm_head = (r_norm_head == LAST_IDX) ? '0 : r_norm_head + 1'b1;
                    n_norm_fill = r_norm_fill - 1'b1;
                    if (!pref_empty) begin
                        n_count = '0;
                    end
                end else begin
                    n_status    = STATUS_SERVED_PREF;
                    pref_read   = 1'b1;
                    n_pref_head = (r_pref_head == LAST_IDX) ? '0 : r_pref_head + 1'b1;
                    n_pref_fill = r_pref_fill - 1'b1;
                    if (r_count < r_threshold) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
        endcase
    end

    // queue stores with registered read into the result stage
    always_ff @(posedge i_clk) begin
        if (accept && norm_write) begin
            r_norm_mem[r_norm_tail] <= s_axis_tdata;
        end
        if (accept && pref_write) begin
            r_pref_mem[r_pref_tail] <= s_axis_tdata;
        end
        if (accept) begin
            r_p_status <= n_status;
            if (norm_read) begin
                r_p_number <= r_norm_mem[r_norm_head];
            end else if (pref_read) begin
                r_p_number <= r_pref_mem[r_pref_head];
            end else begin
                r_p_number <= '0;
            end
        end
        if (out_load) begin
            r_o_status <= r_p_status;
            r_o_number <= r_p_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_head <= '0;
            r_norm_tail <= '0;
            r_norm_fill <= '0;
            r_pref_head <= '0;
            r_pref_tail <= '0;
            r_pref_fill <= '0;
            r_count     <= '0;
            r_threshold <= THRESHOLD_RESET;
            r_p_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
            if (accept) begin
                r_norm_head <= n_norm_head;
                r_norm_tail <= n_norm_tail;
                r_norm_fill <= n_norm_fill;
                r_pref_head <= n_pref_head;
                r_pref_tail <= n_pref_tail;
                r_pref_fill <= n_pref_fill;
                r_count     <= n_count;
                r_p_valid   <= 1'b1;
            end else if (out_load) begin
                r_p_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_number;
    assign m_axis_tuser  = r_o_status;

endmodule

// ===== tb/two_class_weighted_queue_unit_tb.sv =====
// self-checking testbench for the two-class weighted queue unit
module two_class_weighted_queue_unit_tb
    import tcwq_pkg::*;
;

    localparam int    LINE_DEPTH  = 16;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    SEGMENTS    = 8;
    localparam int    SEGMENT_LEN = 110;
    localparam t_func FUNC_SPARE  = 2'd3;

    typedef struct packed {
        t_status status;
        t_number number;
    } t_outcome;

    class ticket_desk;
        t_number  normal_line[$];
        t_number  preferred_line[$];
        t_count   service_count;
        t_count   threshold;
        t_outcome due[$];
        int       mismatch_count;

        function new();
            service_count  = '0;
            threshold      = THRESHOLD_RESET;
            mismatch_count = 0;
        endfunction

        function void set_threshold(t_count v);
            threshold = v;
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            $display("mismatch: %s", msg);
        endtask

        task take_request(t_func f, t_number n);
            t_outcome o;
            bit       take_normal;
            o.number = '0;
            if (f == FUNC_ENQ_NORMAL) begin
                if (normal_line.size() >= LINE_DEPTH) begin
                    o.status = STATUS_FULL;
                end else begin
                    normal_line.push_back(n);
                    o.status = STATUS_ENQUEUED;
                end
            end else if (f == FUNC_ENQ_PREF) begin
                if (preferred_line.size() >= LINE_DEPTH) begin
                    o.status = STATUS_FULL;
                end else begin
                    preferred_line.push_back(n);
                    o.status = STATUS_ENQUEUED;
                end
            end else if (normal_line.size() == 0 && preferred_line.size() == 0) begin
                o.status = STATUS_EMPTY;
            end else begin
                if (preferred_line.size() == 0) begin
                    take_normal = 1'b1;
                end else if (normal_line.size() == 0) begin
                    take_normal = 1'b0;
                end else begin
                    take_normal = (service_count >= threshold);
                end
                if (take_normal) begin
                    o.number = normal_line.pop_front();
                    if (preferred_line.size() != 0) begin
                        service_count = '0;
                    end
                    o.status = STATUS_SERVED_NORMAL;
                end else begin
                    o.number = preferred_line.pop_front();
                    if (service_count < threshold) begin
                        service_count = service_count + 1'b1;
                    end
                    o.status = STATUS_SERVED_PREF;
                end
            end
            due.push_back(o);
        endtask

        task match_outcome(t_status s, t_number n);
            t_outcome want;
            if (due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result status %0d ticket %h", s, n));
                return;
            end
            want = due.pop_front();
            if (s !== want.status) begin
                flag_mismatch($sformatf("status %0d, wanted %0d", s, want.status));
            end
            if (n !== want.number) begin
                flag_mismatch($sformatf("ticket %h, wanted %h", n, want.number));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    t_count      i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    t_number     s_axis_tdata  = '0;
    t_func       s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    t_number     m_axis_tdata;
    t_status     m_axis_tuser;

    ticket_desk  desk = new();
    int          send_idle  = 0;
    int          recv_stall = 0;
    int          cycles     = 0;

    two_class_weighted_queue_unit #(
        .QUEUE_DEPTH(LINE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                desk.match_outcome(m_axis_tuser, m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                desk.take_request(s_axis_tuser, s_axis_tdata);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                desk.set_threshold(i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task send_request(t_func f, t_number n);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= n;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // look at the scoreboard only away from the sampling edge
    task wait_drained();
        @(negedge i_clk);
        while (desk.due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task write_threshold(t_count v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_number pick_ticket();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return t_number'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_func pick_func(int enq_share);
        if ($urandom_range(99) < enq_share) begin
            return $urandom_range(1) ? FUNC_ENQ_PREF : FUNC_ENQ_NORMAL;
        end
        return ($urandom_range(7) == 0) ? FUNC_SPARE : FUNC_SERVE;
    endfunction

    initial begin
        t_count thresholds [SEGMENTS];
        int     enq_shares [SEGMENTS];
        thresholds = '{4'd0, 4'd15, 4'd1, 4'd5, 4'd0, 4'd15, 4'd1, 4'd9};
        enq_shares = '{50, 70, 35, 55, 45, 65, 30, 50};
        thresholds[7] = t_count'($urandom_range(2, 14));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queues, spare code, fill normal to the top, then mixed serves
        send_request(FUNC_SERVE, 16'h1234);
        send_request(FUNC_SPARE, 16'hFFFF);
        send_request(FUNC_ENQ_NORMAL, 16'h0000);
        send_request(FUNC_ENQ_NORMAL, 16'hFFFF);
        for (int k = 0; k < LINE_DEPTH - 2; k++) begin
            send_request(FUNC_ENQ_NORMAL, pick_ticket());
        end
        send_request(FUNC_ENQ_NORMAL, 16'hBEEF);
        send_request(FUNC_ENQ_PREF, 16'hFFFF);
        send_request(FUNC_ENQ_PREF, 16'h0000);
        send_request(FUNC_SERVE, 16'h0000);
        send_request(FUNC_SPARE, 16'h0000);
        send_request(FUNC_SERVE, 16'hFFFF);
        send_request(FUNC_SERVE, 16'h0000);
        s_axis_tvalid <= 1'b0;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_threshold(thresholds[seg]);
            case (seg % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            for (int k = 0; k < SEGMENT_LEN; k++) begin
                send_request(pick_func(enq_shares[seg]), pick_ticket());
            end
            s_axis_tvalid <= 1'b0;
        end

        recv_stall = 0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (desk.mismatch_count == 0 && desk.due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
